>>> sv/round_robin_task_scheduler_macros.svh
// Assertion macros shared by the round-robin task scheduler RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rrts_pkg.sv
// Package for the round-robin task scheduler: widths, codes, table entry
// and controller/datapath interface structs. No dependencies.
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS_DEF = 128;
    localparam int BURST_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int TIME_W        = 24;
    localparam int QUANT_W       = 8;
    localparam int INDEX_W       = 7;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

    localparam logic ACTION_ADD  = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    // One row of the task table.
    typedef struct packed {
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] original;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  first_time;
        logic               started;
    } task_entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic add_we;      // append the input task
        logic step_start;  // load scan pointer
        logic scan;        // read one slot, advance pointer
        logic grant;       // compute slice
        logic apply;       // write back, advance time
        logic load_out;    // fill output register
        logic load_blank;  // result is the nothing-to-run result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;  // no task has work left
        logic hit;    // scanned slot has work left
    } status_t;

endpackage

`default_nettype wire

>>> sv/rrts_ctrl.sv
// Controller state machine of the round-robin task scheduler.
// Depends on rrts_pkg and round_robin_task_scheduler_macros.svh.
`default_nettype none
`include "round_robin_task_scheduler_macros.svh"

module rrts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             action,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rrts_pkg::cmd_t        cmd,
    input  wire rrts_pkg::status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT,
        S_APPLY,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   blank_reg;
    logic   accept;
    logic   step_accept;
    logic   out_free;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign step_accept = accept && (action == rrts_pkg::ACTION_STEP);
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        cmd.add_we     = accept && (action == rrts_pkg::ACTION_ADD);
        cmd.step_start = accept && (action == rrts_pkg::ACTION_STEP) && !status.empty;
        cmd.scan       = (state_reg == S_SCAN);
        cmd.grant      = (state_reg == S_GRANT);
        cmd.apply      = (state_reg == S_APPLY);
        cmd.load_out   = (state_reg == S_EMIT) && out_free;
        cmd.load_blank = blank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            blank_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (action == rrts_pkg::ACTION_STEP))
                    begin
                        blank_reg <= status.empty;
                        state_reg <= status.empty ? S_EMIT : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (status.hit)
                    begin
                        state_reg <= S_GRANT;
                    end
                end
                S_GRANT:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `RRTS_ASSERT_IMPLIES(a_scan_has_work, cmd.scan, !status.empty, "scan with no work left")
    `RRTS_ASSERT_IMPLIES(a_load_when_free, cmd.load_out, out_free, "output overwritten")
    `RRTS_ASSERT_NEXT(a_step_leaves_idle, step_accept, state_reg != S_IDLE, "step not started")

endmodule

`default_nettype wire

>>> sv/rrts_dp.sv
// Datapath of the round-robin task scheduler: task table memory, scan
// pointer, time keeping and output register. Depends on rrts_pkg and macros.
`default_nettype none
`include "round_robin_task_scheduler_macros.svh"

module rrts_dp #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [rrts_pkg::QUANT_W-1:0]        cfg_data,
    input  wire rrts_pkg::cmd_t                     cmd,
    output rrts_pkg::status_t                       status,
    input  wire logic [rrts_pkg::PRIO_W-1:0]         task_priority,
    input  wire logic [rrts_pkg::BURST_W-1:0]        task_burst,
    output logic [rrts_pkg::INDEX_W-1:0]             task_index,
    output logic [rrts_pkg::PRIO_W-1:0]              priority_out,
    output logic [rrts_pkg::QUANT_W-1:0]             slice_length,
    output logic [rrts_pkg::BURST_W-1:0]             burst_left,
    output logic [rrts_pkg::TIME_W-1:0]              slice_start,
    output logic                                    task_done,
    output logic [rrts_pkg::TIME_W-1:0]              first_run_time,
    output logic [rrts_pkg::TIME_W-1:0]              finish_time,
    output logic [rrts_pkg::TIME_W-1:0]              wait_time,
    output logic                                    all_done
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int TW    = rrts_pkg::TIME_W;
    localparam int BW    = rrts_pkg::BURST_W;
    localparam int QW    = rrts_pkg::QUANT_W;

    rrts_pkg::task_entry_t mem [MAX_TASKS];

    logic [QW-1:0]    tq_reg;
    logic [CNT_W-1:0] task_total_reg;
    logic [CNT_W-1:0] active_reg;
    logic [IDX_W-1:0] next_slot_reg;
    logic [TW-1:0]    clock_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_slot_reg;
    rrts_pkg::task_entry_t rd_data_reg;
    rrts_pkg::task_entry_t hit_reg;
    logic [IDX_W-1:0] hit_slot_reg;
    logic [QW-1:0]    slice_reg;
    logic [TW-1:0]    start_reg;
    logic [BW-1:0]    res_rem_reg;
    logic [TW-1:0]    res_first_reg;
    logic             res_done_reg;

    logic             full;
    logic             add_ok;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] slot_inc;
    logic [CNT_W-1:0] next_slot_ext;
    logic [CNT_W-1:0] hit_slot_ext;
    logic [IDX_W-1:0] scan_start;
    logic [QW-1:0]    quantum;
    logic [QW-1:0]    slice_next;
    logic [BW-1:0]    rem_next;
    logic [TW-1:0]    finish;
    logic [TW-1:0]    first_next;
    logic [TW-1:0]    wait_val;
    logic [31:0]      slot_wide;
    rrts_pkg::task_entry_t add_entry;
    rrts_pkg::task_entry_t upd_entry;

    assign full          = (task_total_reg == CNT_W'(MAX_TASKS));
    assign add_ok        = cmd.add_we && !full;
    assign ptr_inc       = CNT_W'(ptr_reg) + CNT_W'(1);
    assign slot_inc      = CNT_W'(hit_slot_reg) + CNT_W'(1);
    assign next_slot_ext = CNT_W'(next_slot_reg);
    assign hit_slot_ext  = CNT_W'(hit_slot_reg);
    assign scan_start    = (next_slot_ext < task_total_reg) ? next_slot_reg : '0;

    assign quantum    = (tq_reg == '0) ? QW'(1) : tq_reg;
    assign slice_next = (hit_reg.remaining > BW'(quantum)) ? quantum : hit_reg.remaining[QW-1:0];
    assign rem_next   = hit_reg.remaining - BW'(slice_reg);
    assign finish     = clock_reg + TW'(slice_reg);
    assign first_next = hit_reg.started ? hit_reg.first_time : clock_reg;
    assign wait_val   = (clock_reg >= TW'(hit_reg.original)) ?
                        (clock_reg - TW'(hit_reg.original)) : '0;
    assign slot_wide  = 32'(hit_slot_reg);

    always_comb
    begin
        add_entry.remaining  = task_burst;
        add_entry.original   = task_burst;
        add_entry.prio       = task_priority;
        add_entry.first_time = '0;
        add_entry.started    = 1'b0;

        upd_entry            = hit_reg;
        upd_entry.remaining  = rem_next;
        upd_entry.first_time = first_next;
        upd_entry.started    = 1'b1;
    end

    assign status.empty = (active_reg == '0);
    assign status.hit   = rd_vld_reg && (rd_data_reg.remaining != '0);

    // Task table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (add_ok)
        begin
            mem[task_total_reg[IDX_W-1:0]] <= add_entry;
        end
        else if (cmd.apply)
        begin
            mem[hit_slot_reg] <= upd_entry;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_reg         <= rrts_pkg::QUANTUM_RESET;
            task_total_reg <= '0;
            active_reg     <= '0;
            next_slot_reg  <= '0;
            clock_reg      <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tq_reg <= cfg_data;
            end
            if (add_ok)
            begin
                task_total_reg <= task_total_reg + CNT_W'(1);
                if (task_burst != '0)
                begin
                    active_reg <= active_reg + CNT_W'(1);
                end
            end
            if (cmd.step_start)
            begin
                rd_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_vld_reg <= 1'b1;
            end
            if (cmd.apply)
            begin
                clock_reg     <= finish;
                next_slot_reg <= (slot_inc >= task_total_reg) ? '0 : slot_inc[IDX_W-1:0];
                if (rem_next == '0)
                begin
                    active_reg <= active_reg - CNT_W'(1);
                end
            end
        end
    end

    // Scan pointer and step working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.step_start)
        begin
            ptr_reg <= scan_start;
        end
        else if (cmd.scan)
        begin
            ptr_reg     <= (ptr_inc >= task_total_reg) ? '0 : ptr_inc[IDX_W-1:0];
            rd_slot_reg <= ptr_reg;
        end
        if (cmd.scan && status.hit)
        begin
            hit_reg      <= rd_data_reg;
            hit_slot_reg <= rd_slot_reg;
        end
        if (cmd.grant)
        begin
            slice_reg <= slice_next;
            start_reg <= clock_reg;
        end
        if (cmd.apply)
        begin
            res_rem_reg   <= rem_next;
            res_first_reg <= first_next;
            res_done_reg  <= (rem_next == '0);
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            all_done <= (active_reg == '0);
            if (cmd.load_blank)
            begin
                task_index     <= '0;
                priority_out   <= '0;
                slice_length   <= '0;
                burst_left     <= '0;
                slice_start    <= '0;
                task_done      <= 1'b0;
                first_run_time <= '0;
                finish_time    <= '0;
                wait_time      <= '0;
            end
            else
            begin
                task_index     <= slot_wide[rrts_pkg::INDEX_W-1:0];
                priority_out   <= hit_reg.prio;
                slice_length   <= slice_reg;
                burst_left     <= res_rem_reg;
                slice_start    <= start_reg;
                task_done      <= res_done_reg;
                first_run_time <= res_done_reg ? res_first_reg : '0;
                finish_time    <= res_done_reg ? clock_reg : '0;
                wait_time      <= res_done_reg ? wait_val : '0;
            end
        end
    end

    `RRTS_ASSERT_IMPLIES(a_active_bound, 1'b1, active_reg <= task_total_reg, "bad active count")
    `RRTS_ASSERT_IMPLIES(a_hit_in_range, cmd.grant, hit_slot_ext < task_total_reg, "slot out of range")
    `RRTS_ASSERT_IMPLIES(a_grant_has_work, cmd.grant, hit_reg.remaining != '0, "idle task granted")

endmodule

`default_nettype wire

>>> sv/round_robin_task_scheduler.sv
// Round-robin task scheduler, top level. An add transaction is written as accepted.
// A step scans slots from the round-robin pointer, one per cycle through the table
// read port, to the first with work left, then grants, applies and emits a result;
// with no work left it skips the scan and emits a blank result. The next transaction
// is taken as the result goes valid, once a result still held by the receiver drains.
// Reset (rst_n, async, active low) empties the table, zeroes time and pointer.
`default_nettype none

module round_robin_task_scheduler #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel: time quantum
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rrts_pkg::QUANT_W-1:0]        cfg_data,
    // input transaction channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               action,
    input  wire logic [rrts_pkg::PRIO_W-1:0]         task_priority,
    input  wire logic [rrts_pkg::BURST_W-1:0]        task_burst,
    // result transaction channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [rrts_pkg::INDEX_W-1:0]             task_index,
    output logic [rrts_pkg::PRIO_W-1:0]              priority_out,
    output logic [rrts_pkg::QUANT_W-1:0]             slice_length,
    output logic [rrts_pkg::BURST_W-1:0]             burst_left,
    output logic [rrts_pkg::TIME_W-1:0]              slice_start,
    output logic                                    task_done,
    output logic [rrts_pkg::TIME_W-1:0]              first_run_time,
    output logic [rrts_pkg::TIME_W-1:0]              finish_time,
    output logic [rrts_pkg::TIME_W-1:0]              wait_time,
    output logic                                    all_done
);

    rrts_pkg::cmd_t    cmd;
    rrts_pkg::status_t status;

    // The quantum register takes a write in any cycle, reset value 10; write
    // it only while no step is in flight.
    assign cfg_ready = 1'b1;

    // Controller: sequences add, scan, grant, apply and emit.
    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: task table, scan pointer, clock and result register.
    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .task_priority  (task_priority),
        .task_burst     (task_burst),
        .task_index     (task_index),
        .priority_out   (priority_out),
        .slice_length   (slice_length),
        .burst_left     (burst_left),
        .slice_start    (slice_start),
        .task_done      (task_done),
        .first_run_time (first_run_time),
        .finish_time    (finish_time),
        .wait_time      (wait_time),
        .all_done       (all_done)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for round_robin_task_scheduler: directed and random
// add/step transactions checked against an in-bench round-robin predictor.
// Depends on rrts_pkg and the scheduler RTL only.
`default_nettype none

module tb;

    localparam int PRIO_W          = rrts_pkg::PRIO_W;
    localparam int BURST_W         = rrts_pkg::BURST_W;
    localparam int INDEX_W         = rrts_pkg::INDEX_W;
    localparam int QUANT_W         = rrts_pkg::QUANT_W;
    localparam int TIME_W          = rrts_pkg::TIME_W;
    localparam int TABLE_SLOTS     = rrts_pkg::MAX_TASKS_DEF;
    // A step may scan every slot, one per cycle, plus its grant, apply and emit states.
    localparam int SCAN_SETTLE     = rrts_pkg::MAX_TASKS_DEF + 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct packed {
        logic               action;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } task_request_t;

    typedef struct packed {
        logic [INDEX_W-1:0] task_index;
        logic [PRIO_W-1:0]  priority_out;
        logic [QUANT_W-1:0] slice_length;
        logic [BURST_W-1:0] burst_left;
        logic [TIME_W-1:0]  slice_start;
        logic               task_done;
        logic [TIME_W-1:0]  first_run_time;
        logic [TIME_W-1:0]  finish_time;
        logic [TIME_W-1:0]  wait_time;
        logic               all_done;
    } slice_grant_t;

    // Clock, reset and block inputs; every input holds a known value from time 0.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [QUANT_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               action = rrts_pkg::ACTION_ADD;
    logic [PRIO_W-1:0]  task_priority = '0;
    logic [BURST_W-1:0] task_burst = '0;
    logic               out_ready = 1'b0;

    // Block outputs.
    logic               cfg_ready;
    logic               in_ready;
    logic               out_valid;
    logic [INDEX_W-1:0] task_index;
    logic [PRIO_W-1:0]  priority_out;
    logic [QUANT_W-1:0] slice_length;
    logic [BURST_W-1:0] burst_left;
    logic [TIME_W-1:0]  slice_start;
    logic               task_done;
    logic [TIME_W-1:0]  first_run_time;
    logic [TIME_W-1:0]  finish_time;
    logic [TIME_W-1:0]  wait_time;
    logic               all_done;

    // Stimulus queue, expected grants and run bookkeeping.
    task_request_t      task_requests[$];
    slice_grant_t       expected_grants[$];
    task_request_t      drive_req;
    slice_grant_t       want_grant;
    int                 adds_queued = 0;
    int                 grants_seen = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 33;
    int                 rx_idle_pct = 33;
    logic               hold_off = 1'b0;

    // Predictor state: the task table, its fill level, the round-robin
    // pointer, scheduler time and the quantum register.
    logic [BURST_W-1:0] tbl_remaining[TABLE_SLOTS];
    logic [BURST_W-1:0] tbl_original[TABLE_SLOTS];
    logic [PRIO_W-1:0]  tbl_prio[TABLE_SLOTS];
    logic [TIME_W-1:0]  tbl_first[TABLE_SLOTS];
    logic               tbl_started[TABLE_SLOTS];
    int unsigned        table_count = 0;
    int unsigned        rr_ptr = 0;
    logic [TIME_W-1:0]  sched_time = '0;
    logic [QUANT_W-1:0] quantum_q = rrts_pkg::QUANTUM_RESET;

    round_robin_task_scheduler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .task_priority  (task_priority),
        .task_burst     (task_burst),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .task_index     (task_index),
        .priority_out   (priority_out),
        .slice_length   (slice_length),
        .burst_left     (burst_left),
        .slice_start    (slice_start),
        .task_done      (task_done),
        .first_run_time (first_run_time),
        .finish_time    (finish_time),
        .wait_time      (wait_time),
        .all_done       (all_done)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Apply one accepted transaction to the predictor. An add appends a task
    // (dropped when the table is full); a step grants the next task with work
    // left, or a blank grant if none, and queues the grant it should produce.
    task automatic schedule_request(input logic act, input logic [PRIO_W-1:0] prio,
                                    input logic [BURST_W-1:0] burst);
        slice_grant_t       grant;
        int unsigned        first;
        int unsigned        slot;
        int unsigned        s;
        int unsigned        k;
        bit                 found;
        logic [BURST_W-1:0] q;
        logic [BURST_W-1:0] slice;
        logic [TIME_W-1:0]  finish;
        logic [TIME_W-1:0]  orig_ext;

        if (act == rrts_pkg::ACTION_ADD) begin
            if (table_count < TABLE_SLOTS) begin
                tbl_remaining[table_count] = burst;
                tbl_original[table_count]  = burst;
                tbl_prio[table_count]      = prio;
                tbl_first[table_count]     = '0;
                tbl_started[table_count]   = 1'b0;
                table_count++;
            end
            return;
        end

        grant = '0;
        found = 1'b0;
        slot  = 0;
        first = (rr_ptr < table_count) ? rr_ptr : 0;
        for (k = 0; k < table_count; k++) begin
            s = first + k;
            if (s >= table_count)
                s -= table_count;
            if (!found && tbl_remaining[s] != '0) begin
                found = 1'b1;
                slot  = s;
            end
        end

        // Nothing to run: blank grant, state untouched.
        if (!found) begin
            grant.all_done = 1'b1;
            expected_grants.push_back(grant);
            return;
        end

        if (!tbl_started[slot]) begin
            tbl_started[slot] = 1'b1;
            tbl_first[slot]   = sched_time;
        end
        // A zero quantum behaves as one.
        q     = (quantum_q == '0) ? BURST_W'(1) : BURST_W'(quantum_q);
        slice = (tbl_remaining[slot] > q) ? q : tbl_remaining[slot];

        grant.task_index   = INDEX_W'(slot);
        grant.priority_out = tbl_prio[slot];
        grant.slice_length = slice[QUANT_W-1:0];
        grant.slice_start  = sched_time;

        tbl_remaining[slot] = tbl_remaining[slot] - slice;
        sched_time          = sched_time + TIME_W'(slice);
        grant.burst_left    = tbl_remaining[slot];

        if (tbl_remaining[slot] == '0) begin
            finish   = sched_time;
            orig_ext = TIME_W'(tbl_original[slot]);
            grant.task_done      = 1'b1;
            grant.first_run_time = tbl_first[slot];
            grant.finish_time    = finish;
            // Saturate at zero should the time ever wrap below the burst.
            grant.wait_time      = (finish >= orig_ext) ? finish - orig_ext : '0;
        end

        rr_ptr = slot + 1;
        if (rr_ptr >= table_count)
            rr_ptr = 0;

        grant.all_done = 1'b1;
        for (k = 0; k < table_count; k++)
            if (tbl_remaining[k] != '0)
                grant.all_done = 1'b0;
        expected_grants.push_back(grant);
    endtask

    function automatic void check_field(input string label, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endfunction

    // Driver: record the accepted transaction in the predictor, then offer the
    // next request unless this cycle is an idle one. Hold valid and payload
    // while the block stalls.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                schedule_request(action, task_priority, task_burst);
            if (!in_valid || in_ready) begin
                if (task_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drive_req     = task_requests.pop_front();
                    in_valid      <= 1'b1;
                    action        <= drive_req.action;
                    task_priority <= drive_req.prio;
                    task_burst    <= drive_req.burst;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted grant with the oldest expected one, then
    // pick the next cycle's ready, honoring the long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: grant with none expected, expected nothing, actual task %0d",
                             $time, task_index);
                    fail_count++;
                end else begin
                    want_grant = expected_grants.pop_front();
                    grants_seen++;
                    check_field("task_index", want_grant.task_index, task_index);
                    check_field("priority_out", want_grant.priority_out, priority_out);
                    check_field("slice_length", want_grant.slice_length, slice_length);
                    check_field("burst_left", want_grant.burst_left, burst_left);
                    check_field("slice_start", want_grant.slice_start, slice_start);
                    check_field("task_done", want_grant.task_done, task_done);
                    check_field("first_run_time", want_grant.first_run_time, first_run_time);
                    check_field("finish_time", want_grant.finish_time, finish_time);
                    check_field("wait_time", want_grant.wait_time, wait_time);
                    check_field("all_done", want_grant.all_done, all_done);
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Back-pressure: once traffic is flowing, drop ready for a long stretch so
    // the grant path fills and the block stalls its input.
    initial
    begin
        wait (grants_seen >= 120);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic push_add(input logic [PRIO_W-1:0] prio, input logic [BURST_W-1:0] burst);
        task_requests.push_back('{action: rrts_pkg::ACTION_ADD, prio: prio, burst: burst});
        adds_queued++;
    endtask

    task automatic push_step();
        task_requests.push_back('{action: rrts_pkg::ACTION_STEP, prio: '0, burst: '0});
    endtask

    // Mostly short bursts so tasks finish within a phase; some zero bursts
    // that must never be scheduled, and a thin tail of longer ones.
    function automatic logic [BURST_W-1:0] random_burst();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return '0;
        else if (pick < 75)
            return BURST_W'($urandom_range(12, 1));
        else if (pick < 96)
            return BURST_W'($urandom_range(120, 13));
        else
            return BURST_W'($urandom_range(800, 121));
    endfunction

    // Groups of adds followed by runs of steps, with lone steps mixed in.
    // Keep the last table slot free for the final phase.
    task automatic push_random_phase(input int n_items);
        int left;
        int n_add;
        int n_step;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                push_step();
                left--;
            end else begin
                n_add  = $urandom_range(4, 1);
                n_step = $urandom_range(8, 1);
                repeat (n_add) begin
                    if (adds_queued < TABLE_SLOTS - 1) begin
                        push_add(PRIO_W'($urandom_range(255)), random_burst());
                        left--;
                    end
                end
                repeat (n_step) begin
                    push_step();
                    left--;
                end
            end
        end
    endtask

    // Wait until every request is accepted and every grant checked, then let
    // the SCAN_SETTLE margin pass before the next phase.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (task_requests.size() != 0 || in_valid || expected_grants.size() != 0);
        repeat (SCAN_SETTLE) @(posedge clk);
    endtask

    // Write the quantum register over its own channel; update the predictor
    // on the accepting edge.
    task automatic write_quantum(input logic [QUANT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        quantum_q = value;
    endtask

    initial
    begin
        logic [QUANT_W-1:0] phase_quanta[5];

        phase_quanta[0] = 8'd255;
        phase_quanta[1] = 8'd1;
        phase_quanta[2] = QUANT_W'($urandom_range(254, 2));
        phase_quanta[3] = 8'd0;
        phase_quanta[4] = QUANT_W'($urandom_range(254, 2));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, at the reset quantum: step on an empty table, a zero-burst
        // task that is never run, extreme priorities, bursts below, at and just
        // above the quantum, then steps through to all done and past it.
        push_step();
        push_add(8'h00, 16'd0);
        push_step();
        push_add(8'hFF, 16'd1);
        push_add(8'hA5, 16'd25);
        push_add(8'h3C, 16'd10);
        push_add(8'h5A, 16'd11);
        repeat (9) push_step();
        wait_idle();

        // Zero quantum acts as one.
        write_quantum(8'd0);
        push_add(8'h01, 16'd3);
        repeat (4) push_step();
        wait_idle();

        // Random phases, one quantum each; the middle one runs without idling.
        foreach (phase_quanta[i]) begin
            write_quantum(phase_quanta[i]);
            if (i == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            push_random_phase(90);
            wait_idle();
            tx_idle_pct = 33;
            rx_idle_pct = 33;
        end

        // Last phase: fill the table, put a maximal burst in the top slot,
        // offer one add too many, then keep stepping. Scheduler time can't
        // wrap: a full table's total burst stays under 2^24.
        write_quantum(8'd255);
        while (adds_queued < TABLE_SLOTS - 1)
            push_add(PRIO_W'($urandom_range(255)), random_burst());
        push_add(PRIO_W'($urandom_range(255)), 16'hFFFF);
        push_add(8'h77, 16'd5);
        repeat (60) push_step();
        wait_idle();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_task_scheduler.sv
test/tb.sv
